@@ rtl/core/xs_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// xs_pkg
// Shared types and constants of the xoshiro256** generator: field widths,
// splitmix64 and scrambler constants, command codes, register map and the
// sequencer states of the back end.
// ----------------------------------------------------------------------------
package xs_pkg;

	// field widths
	localparam int WORD_W         = 64;
	localparam int FRAC_W         = 53;
	localparam int PROB_W         = 54;
	localparam int RANGE_BITS_DEF = 16;
	localparam int MUL_W          = 32;
	// low slice of the fraction that goes through the second index product
	localparam int LO_W           = 21;
	localparam int LO_PROD_W      = 53;

	// splitmix64 constants
	localparam logic [WORD_W-1:0] GOLDEN_GAMMA = 64'h9E37_79B9_7F4A_7C15;
	localparam logic [WORD_W-1:0] MIX_MUL_A    = 64'hBF58_476D_1CE4_E5B9;
	localparam logic [WORD_W-1:0] MIX_MUL_B    = 64'h94D0_49BB_1331_11EB;
	localparam int MIX_SH_0 = 30;
	localparam int MIX_SH_1 = 27;
	localparam int MIX_SH_2 = 31;

	// xoshiro256** constants
	localparam int XS_SHL   = 17;
	localparam int XS_ROT   = 45;
	localparam int SCR_ROT  = 7;

	// command codes of the input word
	localparam logic CMD_GENERATE = 1'b0;
	localparam logic CMD_RESEED   = 1'b1;

	typedef enum logic {
		OP_GENERATE,
		OP_RESEED
	} op_t;

	// decoded queue entry
	typedef struct packed {
		op_t               op;
		logic [PROB_W-1:0] prob;
	} head_t;

	// command queue geometry
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// APB register map: register i at byte address 8*i
	localparam int APB_AW = 4;
	localparam int APB_DW = 64;
	localparam logic REG_SEED = 1'b0;

	// back-end sequencer
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MIX_ADD,
		ST_MUL0,
		ST_MUL1,
		ST_MUL2,
		ST_MIX_XOR,
		ST_SCR,
		ST_HI,
		ST_LO,
		ST_SUM
	} eng_state_t;

	function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x, input int k);
		rotl = (x << k) | (x >> (WORD_W - k));
	endfunction

endpackage
`default_nettype wire

@@ rtl/core/xs_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// xs_if
// Valid/ready channels of the generator: the command channel and the
// result channel.
// ----------------------------------------------------------------------------
interface xs_cmd_if
	import xs_pkg::*;
#(
	parameter int RANGE_BITS = RANGE_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	logic                  command;
	logic [PROB_W-1:0]     probability;
	logic [RANGE_BITS-1:0] range_n;

	modport source (output valid, command, probability, range_n, input ready);
	modport sink   (input valid, command, probability, range_n, output ready);
endinterface

interface xs_res_if
	import xs_pkg::*;
#(
	parameter int RANGE_BITS = RANGE_BITS_DEF
);
	logic                  valid;
	logic                  ready;
	logic [WORD_W-1:0]     raw_word;
	logic [FRAC_W-1:0]     fraction;
	logic                  below_probability;
	logic [RANGE_BITS-1:0] index;

	modport source (output valid, raw_word, fraction, below_probability, index, input ready);
	modport sink   (input valid, raw_word, fraction, below_probability, index, output ready);
endinterface
`default_nettype wire

@@ rtl/core/xs_cmd_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// xs_cmd_queue
// Front end: accepts command words, decodes the command code and holds them
// in a short queue for the back end.
// ----------------------------------------------------------------------------
module xs_cmd_queue
	import xs_pkg::*;
#(
	parameter int RANGE_BITS = RANGE_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	xs_cmd_if.sink                     cmd,
	output logic                       head_valid,
	output head_t                      head,
	output logic [RANGE_BITS-1:0]      head_n,
	input  wire logic                  head_pop
);

	head_t                 ent_q   [QUEUE_DEPTH];
	logic [RANGE_BITS-1:0] ent_n_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]     wr_ptr_q;
	logic [QPTR_W-1:0]     rd_ptr_q;
	logic [QCNT_W-1:0]     count_q;
	logic                  push;
	head_t                 in_ent;

	assign cmd.ready  = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign push       = cmd.valid && cmd.ready;
	assign head_valid = (count_q != '0);
	assign head       = ent_q[rd_ptr_q];
	assign head_n     = ent_n_q[rd_ptr_q];

	// decode the incoming word
	always_comb begin
		in_ent.prob = cmd.probability;
		unique case (cmd.command)
			CMD_RESEED:   in_ent.op = OP_RESEED;
			CMD_GENERATE: in_ent.op = OP_GENERATE;
			default:      in_ent.op = OP_GENERATE;
		endcase
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (head_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !head_pop)
				count_q <= count_q + 1'b1;
			else if (!push && head_pop)
				count_q <= count_q - 1'b1;
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q]   <= in_ent;
			ent_n_q[wr_ptr_q] <= cmd.range_n;
		end
	end

endmodule
`default_nettype wire

@@ rtl/core/xs_engine.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// xs_engine
// Back end: holds the four state words, runs the splitmix64 expansion and
// the xoshiro256** step, and forms the result word. One shared 32x32
// multiplier serves the 64-bit mixing products and the index product.
// ----------------------------------------------------------------------------
module xs_engine
	import xs_pkg::*;
#(
	parameter int RANGE_BITS = RANGE_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  head_valid,
	input  wire head_t                 head,
	input  wire logic [RANGE_BITS-1:0] head_n,
	output logic                       head_pop,
	input  wire logic [WORD_W-1:0]     seed_value,
	xs_res_if.source                   res
);

	eng_state_t            state_q;
	eng_state_t            state_d;

	logic [WORD_W-1:0]     s_q [4];
	logic [WORD_W-1:0]     acc_q;
	logic [WORD_W-1:0]     z_q;
	logic [WORD_W-1:0]     prod_q;
	logic [LO_PROD_W-1:0]  lo_q;
	logic [1:0]            k_q;
	logic                  phase_q;
	logic [PROB_W-1:0]     prob_q;
	logic [RANGE_BITS-1:0] n_q;
	logic [WORD_W-1:0]     word_q;
	logic                  below_q;

	logic                  res_valid_q;
	logic [WORD_W-1:0]     out_word_q;
	logic                  out_below_q;
	logic [RANGE_BITS-1:0] out_idx_q;

	logic                  out_free;
	logic                  out_load;
	logic [MUL_W-1:0]      mul_a;
	logic [MUL_W-1:0]      mul_b;
	logic [WORD_W-1:0]     mul_p;
	logic [WORD_W-1:0]     mix_const;
	logic [WORD_W-1:0]     mix_sum;
	logic [WORD_W-1:0]     scr_rot;
	logic [WORD_W-1:0]     idx_sum;

	assign mix_const = phase_q ? MIX_MUL_B : MIX_MUL_A;
	assign mix_sum   = acc_q + GOLDEN_GAMMA;
	assign scr_rot   = rotl(z_q, SCR_ROT);
	assign idx_sum   = prod_q + WORD_W'(lo_q >> LO_W);
	assign mul_p     = WORD_W'(mul_a) * WORD_W'(mul_b);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (head_valid)
					state_d = (head.op == OP_RESEED) ? ST_MIX_ADD : ST_SCR;
			end
			ST_MIX_ADD: state_d = ST_MUL0;
			ST_MUL0:    state_d = ST_MUL1;
			ST_MUL1:    state_d = ST_MUL2;
			ST_MUL2:    state_d = ST_MIX_XOR;
			ST_MIX_XOR: begin
				if (!phase_q)
					state_d = ST_MUL0;
				else if (k_q == 2'd3)
					state_d = ST_IDLE;
				else
					state_d = ST_MIX_ADD;
			end
			ST_SCR:     state_d = ST_HI;
			ST_HI:      state_d = ST_LO;
			ST_LO:      state_d = ST_SUM;
			ST_SUM: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default:    state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs: queue pop, result load, multiplier operands
	always_comb begin
		out_free = !res_valid_q || res.ready;
		head_pop = (state_q == ST_IDLE) && head_valid;
		out_load = (state_q == ST_SUM) && out_free;
		mul_a    = '0;
		mul_b    = '0;
		unique case (state_q)
			ST_MUL0: begin
				mul_a = z_q[31:0];
				mul_b = mix_const[31:0];
			end
			ST_MUL1: begin
				mul_a = z_q[63:32];
				mul_b = mix_const[31:0];
			end
			ST_MUL2: begin
				mul_a = z_q[31:0];
				mul_b = mix_const[63:32];
			end
			ST_HI: begin
				mul_a = word_q[63:32];
				mul_b = MUL_W'(n_q);
			end
			ST_LO: begin
				mul_a = MUL_W'(word_q[WORD_W-FRAC_W+LO_W-1:WORD_W-FRAC_W]);
				mul_b = MUL_W'(n_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// control registers; reset starts the expansion of seed zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_MIX_ADD;
			acc_q       <= '0;
			k_q         <= '0;
			phase_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (head_pop && head.op == OP_RESEED) begin
				acc_q   <= seed_value;
				k_q     <= '0;
				phase_q <= 1'b0;
			end
			if (state_q == ST_MIX_ADD)
				acc_q <= mix_sum;
			if (state_q == ST_MIX_XOR) begin
				phase_q <= !phase_q;
				if (phase_q)
					k_q <= k_q + 1'b1;
			end
			if (out_load)
				res_valid_q <= 1'b1;
			else if (res.ready)
				res_valid_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		// state advance; z_q picks up s1*5 for the scrambler
		if (head_pop && head.op == OP_GENERATE) begin
			z_q    <= s_q[1] + (s_q[1] << 2);
			s_q[0] <= s_q[0] ^ s_q[3] ^ s_q[1];
			s_q[1] <= s_q[1] ^ s_q[2] ^ s_q[0];
			s_q[2] <= s_q[2] ^ s_q[0] ^ (s_q[1] << XS_SHL);
			s_q[3] <= rotl(s_q[3] ^ s_q[1], XS_ROT);
			prob_q <= head.prob;
			n_q    <= head_n;
		end
		case (state_q)
			ST_MIX_ADD: z_q <= mix_sum ^ (mix_sum >> MIX_SH_0);
			// 64x64 low product from three 32x32 partial products
			ST_MUL0:    prod_q <= mul_p;
			ST_MUL1,
			ST_MUL2:    prod_q[63:32] <= prod_q[63:32] + mul_p[31:0];
			ST_MIX_XOR: begin
				if (!phase_q)
					z_q <= prod_q ^ (prod_q >> MIX_SH_1);
				else
					s_q[k_q] <= prod_q ^ (prod_q >> MIX_SH_2);
			end
			// rotl(s1*5, 7) * 9
			ST_SCR:     word_q <= scr_rot + (scr_rot << 3);
			ST_HI: begin
				prod_q  <= mul_p;
				below_q <= PROB_W'(word_q[63:11]) < prob_q;
			end
			ST_LO:      lo_q <= mul_p[LO_PROD_W-1:0];
			default: ;
		endcase
		// result register
		if (out_load) begin
			out_word_q  <= word_q;
			out_below_q <= below_q;
			out_idx_q   <= idx_sum[32 +: RANGE_BITS];
		end
	end

	assign res.valid             = res_valid_q;
	assign res.raw_word          = out_word_q;
	assign res.fraction          = out_word_q[63:11];
	assign res.below_probability = out_below_q;
	assign res.index             = out_idx_q;

endmodule
`default_nettype wire

@@ rtl/core/xoshiro256ss_generator.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// xoshiro256ss_generator
// xoshiro256** random number source with splitmix64 seeding, a valid/ready
// command channel, a valid/ready result channel and an APB seed register.
// ----------------------------------------------------------------------------
// A generate word (command 0) advances the state and returns one result word
// with the raw output, its top 53 bits as a fraction, a flag for fraction
// below probability and an index floor(fraction*range_n/2^53); a reseed word
// (command 1) expands the seed register into the state and returns nothing.
// Commands enter a two-word queue, so the command side is taken while the
// back end works or a result waits. The back end is a sequencer around one
// 32x32 multiplier: a generate runs the scrambler, the high and low index
// products and the sum; a reseed runs four splitmix64 steps. After reset the
// back end expands seed zero before it serves the first queued word.
// The seed register is at byte address 0; write it only while idle.
// ----------------------------------------------------------------------------
module xoshiro256ss_generator
	import xs_pkg::*;
#(
	parameter int RANGE_BITS = RANGE_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	xs_cmd_if.sink                 cmd,
	xs_res_if.source               res,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0]      prdata,
	output logic                   pready
);

	logic [WORD_W-1:0]     seed_q;
	logic                  cfg_wr;
	logic                  head_valid;
	head_t                 head;
	logic [RANGE_BITS-1:0] head_n;
	logic                  head_pop;

	// APB seed register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[APB_AW-1])
				REG_SEED: seed_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[APB_AW-1])
			REG_SEED: prdata = seed_q;
			default:  prdata = '0;
		endcase
	end

	// front end: command queue
	xs_cmd_queue #(
		.RANGE_BITS (RANGE_BITS)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.head_valid (head_valid),
		.head       (head),
		.head_n     (head_n),
		.head_pop   (head_pop)
	);

	// back end: state and result datapath
	xs_engine #(
		.RANGE_BITS (RANGE_BITS)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.head_n     (head_n),
		.head_pop   (head_pop),
		.seed_value (seed_q),
		.res        (res)
	);

endmodule
`default_nettype wire
